### design/art_pkg.sv
package art_pkg;

   // Operation codes carried on the request channel.
   typedef enum logic [1:0] {
      FUNC_SEND = 2'd0,
      FUNC_ACK  = 2'd1,
      FUNC_TICK = 2'd2
   } func_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEND,
      ST_ACK,
      ST_MASK,
      ST_SCAN
   } state_type;

   // Configuration register indexes and reset values.
   localparam int unsigned REG_RETRY_STEP   = 0;
   localparam logic [15:0] RETRY_STEP_RESET = 16'd500;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic do_send;
      logic do_ack;
      logic do_mask;
      logic fire;
      logic step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cur_fire;
      logic idx_last;
      logic out_free;
   } status_type;

endpackage

### design/ack_retransmit_table.sv
// Channel   Direction  Handshake          Carries
// req_*     in         req_valid/stall    func, now_ms, addresses, CRC, tag
// rsp_*     out        rsp_valid/stall    slot, resend fields, attempt, last
// APB       in         psel/penable       retry_step_ms at byte address 0
//
// A send or an ack first captures the request and then updates the slot
// table. A tick captures the request, takes a mask of the due slots and
// then scans the slots one by one, waiting at each due slot while the
// result register is full. Only one item is in work at a time; req_stall
// is high after acceptance until the item is finished.
// Reset is synchronous and marks every slot inactive and the step as 500.
module ack_retransmit_table #(
   parameter int SLOTS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_dest_addr,
   input  logic [7:0]  req_src_addr,
   input  logic [15:0] req_frame_crc,
   input  logic [7:0]  req_packet_tag,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_slot,
   output logic [7:0]  rsp_resend_tag,
   output logic [7:0]  rsp_resend_dest,
   output logic [7:0]  rsp_resend_src,
   output logic [15:0] rsp_resend_crc,
   output logic [7:0]  rsp_attempt,
   output logic        rsp_last,
   // Configuration port.
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import art_pkg::*;

   cmd_type     cmd;
   status_type  status;
   logic [15:0] retry_step_ff;
   logic        csr_write;

   // There is a single register, so every address in the 4-byte window
   // selects it. Writes complete in the access phase since pready is tied high.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = {16'd0, retry_step_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_step_ff <= RETRY_STEP_RESET;
      end else if (csr_write && (paddr[1:0] == 2'd0 || paddr[1:0] != 2'd0)) begin
         retry_step_ff <= pwdata[15:0];
      end
   end

   // The controller sequences each item; the datapath holds the slot table,
   // the tick scan pointer and the result register.
   art_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   art_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .retry_step      (retry_step_ff),
      .req_now_ms      (req_now_ms),
      .req_dest_addr   (req_dest_addr),
      .req_src_addr    (req_src_addr),
      .req_frame_crc   (req_frame_crc),
      .req_packet_tag  (req_packet_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot        (rsp_slot),
      .rsp_resend_tag  (rsp_resend_tag),
      .rsp_resend_dest (rsp_resend_dest),
      .rsp_resend_src  (rsp_resend_src),
      .rsp_resend_crc  (rsp_resend_crc),
      .rsp_attempt     (rsp_attempt),
      .rsp_last        (rsp_last)
   );

endmodule

### design/art_ctrl.sv
module art_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   output logic                req_stall,
   input  art_pkg::status_type status,
   output art_pkg::cmd_type    cmd
);
   import art_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_SEND: state_in = ST_SEND;
                  FUNC_ACK:  state_in = ST_ACK;
                  FUNC_TICK: state_in = ST_MASK;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEND: state_in = ST_IDLE;
         ST_ACK:  state_in = ST_IDLE;
         ST_MASK: state_in = ST_SCAN;
         ST_SCAN: begin
            if ((!status.cur_fire || status.out_free) && status.idx_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.load_req = accept;
         ST_SEND: cmd.do_send  = 1'b1;
         ST_ACK:  cmd.do_ack   = 1'b1;
         ST_MASK: cmd.do_mask  = 1'b1;
         ST_SCAN: begin
            // A due slot waits here until the result register is free.
            cmd.fire = status.cur_fire && status.out_free;
            cmd.step = !status.cur_fire || status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### design/art_dp.sv
module art_dp #(
   parameter int SLOTS = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  art_pkg::cmd_type    cmd,
   output art_pkg::status_type status,
   input  logic [15:0]         retry_step,
   input  logic [31:0]         req_now_ms,
   input  logic [7:0]          req_dest_addr,
   input  logic [7:0]          req_src_addr,
   input  logic [15:0]         req_frame_crc,
   input  logic [7:0]          req_packet_tag,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [3:0]          rsp_slot,
   output logic [7:0]          rsp_resend_tag,
   output logic [7:0]          rsp_resend_dest,
   output logic [7:0]          rsp_resend_src,
   output logic [15:0]         rsp_resend_crc,
   output logic [7:0]          rsp_attempt,
   output logic                rsp_last
);
   import art_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Slot table.
   logic [7:0]  dest_ff     [SLOTS];
   logic [7:0]  src_ff      [SLOTS];
   logic [15:0] crc_ff      [SLOTS];
   logic [7:0]  tag_ff      [SLOTS];
   logic [31:0] deadline_ff [SLOTS];
   logic [7:0]  sends_ff    [SLOTS];

   // Captured request.
   logic [31:0] now_ff;
   logic [7:0]  rdest_ff;
   logic [7:0]  rsrc_ff;
   logic [15:0] rcrc_ff;
   logic [7:0]  rtag_ff;

   // Tick scan state.
   logic [SLOTS-1:0] mask_ff;
   logic [SLOTS-1:0] mask_in;
   logic [IDX_W-1:0] idx_ff;
   logic [SLOTS-1:0] ack_hit;

   // Result register.
   logic        out_valid_ff;
   logic [3:0]  out_slot_ff;
   logic [7:0]  out_tag_ff;
   logic [7:0]  out_dest_ff;
   logic [7:0]  out_src_ff;
   logic [15:0] out_crc_ff;
   logic [7:0]  out_attempt_ff;
   logic        out_last_ff;

   logic [23:0] backoff;
   logic [31:0] deadline_in;
   logic [7:0]  sends_in;
   logic        more_due;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         mask_in[i] = (sends_ff[i] != 8'd0) && (deadline_ff[i] < now_ff);
         ack_hit[i] = (sends_ff[i] != 8'd0) && (dest_ff[i] == rsrc_ff) &&
                      (src_ff[i] == rdest_ff) && (crc_ff[i] == rcrc_ff);
      end
   end

   always_comb begin
      more_due = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
         if ((IDX_W'(j) > idx_ff) && mask_ff[j]) begin
            more_due = 1'b1;
         end
      end
   end

   assign backoff     = retry_step * sends_ff[idx_ff];
   assign deadline_in = now_ff + {8'd0, backoff};
   assign sends_in    = sends_ff[idx_ff] + 8'd1;

   assign status.cur_fire = mask_ff[idx_ff];
   assign status.idx_last = (idx_ff == IDX_W'(SLOTS - 1));
   assign status.out_free = !out_valid_ff || !rsp_stall;

   // Control state and the send counts, which mark slots active.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            sends_ff[i] <= 8'd0;
         end
         mask_ff      <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.do_send) begin
            for (int i = SLOTS - 1; i > 0; i--) begin
               sends_ff[i] <= sends_ff[i-1];
            end
            sends_ff[0] <= 8'd1;
         end
         if (cmd.do_ack) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (ack_hit[i]) begin
                  sends_ff[i] <= 8'd0;
               end
            end
         end
         if (cmd.do_mask) begin
            mask_ff <= mask_in;
            idx_ff  <= '0;
         end
         // A new result may replace one that leaves in the same cycle.
         if (cmd.fire) begin
            sends_ff[idx_ff] <= sends_in;
            out_valid_ff     <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.step && !status.idx_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         now_ff   <= req_now_ms;
         rdest_ff <= req_dest_addr;
         rsrc_ff  <= req_src_addr;
         rcrc_ff  <= req_frame_crc;
         rtag_ff  <= req_packet_tag;
      end
      if (cmd.do_send) begin
         for (int i = SLOTS - 1; i > 0; i--) begin
            dest_ff[i]     <= dest_ff[i-1];
            src_ff[i]      <= src_ff[i-1];
            crc_ff[i]      <= crc_ff[i-1];
            tag_ff[i]      <= tag_ff[i-1];
            deadline_ff[i] <= deadline_ff[i-1];
         end
         dest_ff[0]     <= rdest_ff;
         src_ff[0]      <= rsrc_ff;
         crc_ff[0]      <= rcrc_ff;
         tag_ff[0]      <= rtag_ff;
         deadline_ff[0] <= now_ff + {16'd0, retry_step};
      end
      if (cmd.do_ack) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (ack_hit[i]) begin
               deadline_ff[i] <= 32'd0;
            end
         end
      end
      if (cmd.fire) begin
         deadline_ff[idx_ff] <= deadline_in;
         out_slot_ff         <= 4'(idx_ff);
         out_tag_ff          <= tag_ff[idx_ff];
         out_dest_ff         <= dest_ff[idx_ff];
         out_src_ff          <= src_ff[idx_ff];
         out_crc_ff          <= crc_ff[idx_ff];
         out_attempt_ff      <= sends_in;
         out_last_ff         <= !more_due;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_slot        = out_slot_ff;
   assign rsp_resend_tag  = out_tag_ff;
   assign rsp_resend_dest = out_dest_ff;
   assign rsp_resend_src  = out_src_ff;
   assign rsp_resend_crc  = out_crc_ff;
   assign rsp_attempt     = out_attempt_ff;
   assign rsp_last        = out_last_ff;

endmodule

### tb/art_tb_pkg.sv
`timescale 1ns / 100ps
package art_tb_pkg;
   import art_pkg::*;

   localparam int SLOT_COUNT = 4;
   // The fourth code of the function field is left unused by the block.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] now_ms;
      logic [7:0]  dest_addr;
      logic [7:0]  src_addr;
      logic [15:0] frame_crc;
      logic [7:0]  packet_tag;
   } request_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic [7:0]  tag;
      logic [7:0]  dest;
      logic [7:0]  src;
      logic [15:0] crc;
      logic [7:0]  attempt;
      logic        last;
   } resend_type;

   class retransmit_table_model;
      logic [15:0] step;
      logic [7:0]  dest [SLOT_COUNT];
      logic [7:0]  src [SLOT_COUNT];
      logic [15:0] crc [SLOT_COUNT];
      logic [7:0]  tag [SLOT_COUNT];
      logic [31:0] deadline [SLOT_COUNT];
      logic [7:0]  sends [SLOT_COUNT];
      resend_type  pending_resends [$];
      int          errors;

      function new();
         step = RETRY_STEP_RESET;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            dest[i] = '0;
            src[i] = '0;
            crc[i] = '0;
            tag[i] = '0;
            deadline[i] = '0;
            sends[i] = '0;
         end
         errors = 0;
      endfunction

      function void set_step(logic [15:0] value);
         step = value;
      endfunction

      function int pending();
         return pending_resends.size();
      endfunction

      function void note_request(request_type rq);
         resend_type burst [$];
         resend_type r;
         if (rq.func == FUNC_SEND) begin
            for (int i = SLOT_COUNT - 1; i > 0; i--) begin
               dest[i] = dest[i - 1];
               src[i] = src[i - 1];
               crc[i] = crc[i - 1];
               tag[i] = tag[i - 1];
               deadline[i] = deadline[i - 1];
               sends[i] = sends[i - 1];
            end
            dest[0] = rq.dest_addr;
            src[0] = rq.src_addr;
            crc[0] = rq.frame_crc;
            tag[0] = rq.packet_tag;
            deadline[0] = rq.now_ms + 32'(step);
            sends[0] = 8'd1;
         end else if (rq.func == FUNC_ACK) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (sends[i] != 0 && dest[i] == rq.src_addr && src[i] == rq.dest_addr &&
                   crc[i] == rq.frame_crc) begin
                  sends[i] = '0;
                  deadline[i] = '0;
               end
            end
         end else if (rq.func == FUNC_TICK) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (sends[i] != 0 && deadline[i] < rq.now_ms) begin
                  deadline[i] = rq.now_ms + 32'(step) * 32'(sends[i]);
                  sends[i] = sends[i] + 8'd1;
                  r.slot = 4'(i);
                  r.tag = tag[i];
                  r.dest = dest[i];
                  r.src = src[i];
                  r.crc = crc[i];
                  r.attempt = sends[i];
                  r.last = 1'b0;
                  burst.push_back(r);
               end
            end
            if (burst.size() > 0)
               burst[burst.size() - 1].last = 1'b1;
            foreach (burst[k])
               pending_resends.push_back(burst[k]);
         end
      endfunction

      function void check_resend(resend_type got);
         resend_type  want;
         string       names [7];
         logic [31:0] want_v [7];
         logic [31:0] got_v [7];
         if (pending_resends.size() == 0) begin
            $display("%0t: resend with none expected: slot %0d tag %0d", $time,
                     got.slot, got.tag);
            errors++;
            return;
         end
         want = pending_resends.pop_front();
         names = '{"slot", "resend_tag", "resend_dest", "resend_src", "resend_crc",
                   "attempt", "last"};
         want_v = '{want.slot, want.tag, want.dest, want.src, want.crc, want.attempt,
                    want.last};
         got_v = '{got.slot, got.tag, got.dest, got.src, got.crc, got.attempt, got.last};
         for (int k = 0; k < 7; k++) begin
            if (want_v[k] !== got_v[k]) begin
               $display("%0t: %s expected %0d actual %0d", $time, names[k], want_v[k],
                        got_v[k]);
               errors++;
            end
         end
      endfunction
   endclass

endpackage

### tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import art_pkg::*;
   import art_tb_pkg::*;

   // The limit is far above the length of the slowest correct run, so the
   // watchdog has a wide margin even with long stalls on the result side.
   localparam int CYCLE_LIMIT   = 400000;
   // A send or an ack leaves nothing to wait for, so the step register is
   // only written after a settling wait that lets the last item finish.
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 40;
   localparam int WRAP_TICKS    = 256;

   logic        clock;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_SEND;
   logic [31:0] req_now_ms = '0;
   logic [7:0]  req_dest_addr = '0;
   logic [7:0]  req_src_addr = '0;
   logic [15:0] req_frame_crc = '0;
   logic [7:0]  req_packet_tag = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_slot;
   logic [7:0]  rsp_resend_tag;
   logic [7:0]  rsp_resend_dest;
   logic [7:0]  rsp_resend_src;
   logic [15:0] rsp_resend_crc;
   logic [7:0]  rsp_attempt;
   logic        rsp_last;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [1:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // Idle and stall rates, in percent, for the two sides of the block.
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;

   // A toggle of hold_req asks the receiver process for one long hold-off.
   logic        hold_req = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   int          cycle_count = 0;
   // Running millisecond clock that most sends and ticks follow.
   logic [31:0] wall_ms = 32'd5000;

   retransmit_table_model shadow;

   ack_retransmit_table #(.SLOTS(SLOT_COUNT)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_now_ms      (req_now_ms),
      .req_dest_addr   (req_dest_addr),
      .req_src_addr    (req_src_addr),
      .req_frame_crc   (req_frame_crc),
      .req_packet_tag  (req_packet_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot        (rsp_slot),
      .rsp_resend_tag  (rsp_resend_tag),
      .rsp_resend_dest (rsp_resend_dest),
      .rsp_resend_src  (rsp_resend_src),
      .rsp_resend_crc  (rsp_resend_crc),
      .rsp_attempt     (rsp_attempt),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hang or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Both channels are watched at the clock edge. Every accepted request
   // updates the shadow table and queues the resends it causes; every
   // accepted result is checked against the oldest queued resend.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         shadow.note_request(request_type'({req_func, req_now_ms, req_dest_addr,
                                            req_src_addr, req_frame_crc,
                                            req_packet_tag}));
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_resend(resend_type'({rsp_slot, rsp_resend_tag, rsp_resend_dest,
                                           rsp_resend_src, rsp_resend_crc, rsp_attempt,
                                           rsp_last}));
   end

   // Result side. Normally it stalls at random; a requested hold-off keeps it
   // stalled for a long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Offers one item, with a random number of idle cycles in front of it, and
   // returns at the edge where the block takes it. Valid stays high on return
   // so that back-to-back items need no extra cycle.
   task automatic offer_request(request_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= rq.func;
      req_now_ms     <= rq.now_ms;
      req_dest_addr  <= rq.dest_addr;
      req_src_addr   <= rq.src_addr;
      req_frame_crc  <= rq.frame_crc;
      req_packet_tag <= rq.packet_tag;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic offer_fields(logic [1:0] func, logic [31:0] now_ms, logic [7:0] dest,
                               logic [7:0] src, logic [15:0] crc, logic [7:0] tag);
      offer_request(request_type'({func, now_ms, dest, src, crc, tag}));
   endtask

   // Stops the request side, waits until the block has gone quiet and then
   // writes the retry step through the register port.
   task automatic write_retry_step(logic [15:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 2'(REG_RETRY_STEP * 4);
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      shadow.set_step(value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Builds one random item. Most items follow the running clock so that
   // entries live long enough to be resent, acked or pushed out; addresses and
   // CRCs often come from a tiny pool so that one ack can hit several slots.
   function automatic request_type make_request();
      request_type rq;
      int          roll;
      int          pick;
      int          live [$];
      roll = $urandom_range(99);
      rq.func = FUNC_UNUSED;
      rq.now_ms = 32'($urandom);
      rq.dest_addr = 8'($urandom);
      rq.src_addr = 8'($urandom);
      rq.frame_crc = 16'($urandom);
      rq.packet_tag = 8'($urandom);
      if (roll < 35) begin
         rq.func = FUNC_SEND;
         if ($urandom_range(1) == 1) begin
            rq.dest_addr = 8'($urandom_range(3));
            rq.src_addr = 8'($urandom_range(3));
            rq.frame_crc = 16'($urandom_range(3));
         end
         wall_ms += $urandom_range(40);
         if ($urandom_range(19) != 0)
            rq.now_ms = wall_ms;
      end else if (roll < 60) begin
         // Most acks answer a packet that is still waiting; the rest are noise.
         rq.func = FUNC_ACK;
         for (int i = 0; i < SLOT_COUNT; i++)
            if (shadow.sends[i] != 0)
               live.push_back(i);
         if (live.size() > 0 && $urandom_range(9) < 8) begin
            pick = live[$urandom_range(live.size() - 1)];
            rq.dest_addr = shadow.src[pick];
            rq.src_addr = shadow.dest[pick];
            rq.frame_crc = shadow.crc[pick];
         end
      end else if (roll < 93) begin
         rq.func = FUNC_TICK;
         wall_ms += $urandom_range(3 * shadow.step + 3);
         if ($urandom_range(19) != 0)
            rq.now_ms = wall_ms;
      end
      // Now and then the clock jumps close to the top of its range, so that
      // deadlines wrap and the plain unsigned compare gets exercised.
      if ($urandom_range(49) == 0)
         wall_ms = 32'hFFFF_FFFF - $urandom_range(200000);
      return rq;
   endfunction

   // One stretch of random items under one step value and one idling pattern.
   // A third of the way in the receiver is told to hold off for a long time.
   task automatic run_random_phase(int sender_pct, int receiver_pct, logic [15:0] step_value);
      request_type rq;
      int          done_items;
      bit          held;
      write_retry_step(step_value);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
      done_items = 0;
      held = 1'b0;
      while (done_items < PHASE_ITEMS) begin
         if (!held && done_items == PHASE_ITEMS / 3) begin
            hold_req <= ~hold_req;
            held = 1'b1;
         end
         rq = make_request();
         offer_request(rq);
         if (rq.func != FUNC_UNUSED)
            done_items++;
      end
   endtask

   initial begin
      shadow = new();
      sender_idle_pct = 20;
      receiver_stall_pct = 62;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with a step of one millisecond. Empty-table ticks come
      // first, then entries whose deadlines wrap past zero.
      write_retry_step(16'd1);
      offer_fields(FUNC_TICK, 32'h0000_0000, 8'h00, 8'h00, 16'h0000, 8'h00);
      offer_fields(FUNC_TICK, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      offer_fields(FUNC_SEND, 32'hFFFF_FFFF, 8'hFF, 8'h00, 16'hFFFF, 8'hFF);
      offer_fields(FUNC_SEND, 32'h0000_0000, 8'h00, 8'hFF, 16'h0000, 8'h00);
      // The unused function code must leave the table alone.
      offer_fields(FUNC_UNUSED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
      offer_fields(FUNC_TICK, 32'h0000_0001, 8'h00, 8'h00, 16'h0000, 8'h00);
      offer_fields(FUNC_TICK, 32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 8'h00);
      // Acks that miss on the CRC or on the address order, then one that hits.
      offer_fields(FUNC_ACK, 32'h0000_0000, 8'hFF, 8'h00, 16'h0001, 8'h00);
      offer_fields(FUNC_ACK, 32'h0000_0000, 8'h00, 8'hFF, 16'h0000, 8'h00);
      offer_fields(FUNC_ACK, 32'h0000_0000, 8'hFF, 8'h00, 16'h0000, 8'h00);
      offer_fields(FUNC_TICK, 32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 8'h00);
      // Five sends to one peer push the oldest entries out of the table, and
      // a single ack then clears every slot that waits on that peer.
      for (int k = 1; k <= 5; k++)
         offer_fields(FUNC_SEND, 32'd100, 8'h05, 8'h06, 16'h1234, 8'(k));
      offer_fields(FUNC_ACK, 32'd0, 8'h06, 8'h05, 16'h1234, 8'h00);
      offer_fields(FUNC_TICK, 32'd1000, 8'h00, 8'h00, 16'h0000, 8'h00);
      offer_fields(FUNC_SEND, 32'd200, 8'hAA, 8'h55, 16'hA5A5, 8'h5A);
      offer_fields(FUNC_SEND, 32'd300, 8'h55, 8'hAA, 16'h5A5A, 8'hA5);
      offer_fields(FUNC_TICK, 32'h8000_0000, 8'h00, 8'h00, 16'h0000, 8'h00);

      // Largest step: the sum lands exactly on the top of the range, which a
      // tick at the same time must not treat as due.
      write_retry_step(16'hFFFF);
      offer_fields(FUNC_SEND, 32'hFFFF_0000, 8'h01, 8'h02, 16'h0003, 8'h04);
      offer_fields(FUNC_TICK, 32'hFFFF_FFFF, 8'h00, 8'h00, 16'h0000, 8'h00);

      // A step of zero puts each deadline at the tick time, so a tick every
      // millisecond resends the entry until its send count wraps to zero and
      // the slot goes inactive.
      write_retry_step(16'd0);
      offer_fields(FUNC_SEND, 32'd1000, 8'h3C, 8'hC3, 16'h0F0F, 8'h77);
      for (int k = 1; k <= WRAP_TICKS; k++)
         offer_fields(FUNC_TICK, 32'(1000 + k), 8'($urandom), 8'($urandom),
                      16'($urandom), 8'($urandom));

      // Random part: first a quick sender and a busy receiver, then the other
      // way round, then both running flat out.
      run_random_phase(20, 62, 16'hFFFF);
      run_random_phase(62, 20, 16'($urandom_range(1, 3000)));
      run_random_phase(0, 0, RETRY_STEP_RESET);

      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (shadow.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
